/* src/pab_pkg.sv */
// shared types and constants for the palette alpha blend block
// no dependencies; imported by every module of the block
package pab_pkg;

  localparam int unsigned PalDepth = 256;
  localparam int unsigned PalAw    = $clog2(PalDepth);
  localparam int unsigned SampleW  = 8;
  localparam int unsigned CountW   = PalAw + 1;
  localparam int unsigned WeightW  = SampleW + 1;
  localparam int unsigned ProdW    = SampleW + WeightW;

  // item kinds carried on the action field
  typedef enum logic [0:0] {
    ACT_BLEND = 1'b0,
    ACT_WRITE = 1'b1
  } pab_action_e;

  // one palette entry as stored in the ram
  typedef struct packed {
    logic [SampleW-1:0] alpha;
    logic [SampleW-1:0] cr;
    logic [SampleW-1:0] cb;
    logic [SampleW-1:0] luma;
  } pab_entry_t;

  // stage advance enables shared with the mix lanes
  typedef struct packed {
    logic prod_en;
    logic sum_en;
  } pab_adv_t;

endpackage

/* src/pab_pal_ram.sv */
// palette store: single-port synchronous ram with a registered read port
// depends on pab_pkg for depth and entry type
module pab_pal_ram
  import pab_pkg::*;
(
  input  logic              clk_i,
  input  logic              we_i,
  input  logic              re_i,
  input  logic [PalAw-1:0]  addr_i,
  input  pab_entry_t        wdata_i,
  output pab_entry_t        rdata_o
);

  pab_entry_t mem_q [PalDepth];
  pab_entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  // registered read port, holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/pab_mix_lane.sv */
// one channel of the blend: (dest*(256-a) + pal*(1+a)) >> 8 over two stages
// depends on pab_pkg for widths and the advance struct
module pab_mix_lane
  import pab_pkg::*;
(
  input  logic               clk_i,
  input  pab_adv_t           adv_i,
  input  logic [SampleW-1:0] dest_i,
  input  logic [SampleW-1:0] pal_i,
  input  logic [SampleW-1:0] alpha_i,
  output logic [SampleW-1:0] mix_o
);

  logic [WeightW-1:0] dest_wt;
  logic [WeightW-1:0] pal_wt;
  logic [ProdW-1:0]   dest_prod_d, dest_prod_q;
  logic [ProdW-1:0]   pal_prod_d, pal_prod_q;
  logic [ProdW-1:0]   sum;
  logic [SampleW-1:0] mix_d, mix_q;

  // weights: 256-a and 1+a, both in 1..256
  assign dest_wt = WeightW'(1 << SampleW) - {1'b0, alpha_i};
  assign pal_wt  = {1'b0, alpha_i} + WeightW'(1);

  assign dest_prod_d = ProdW'({{WeightW{1'b0}}, dest_i} * {{SampleW{1'b0}}, dest_wt});
  assign pal_prod_d  = ProdW'({{WeightW{1'b0}}, pal_i} * {{SampleW{1'b0}}, pal_wt});

  // product stage
  always_ff @(posedge clk_i) begin
    if (adv_i.prod_en) begin
      dest_prod_q <= dest_prod_d;
      pal_prod_q  <= pal_prod_d;
    end
  end

  // sum and scale stage
  assign sum   = dest_prod_q + pal_prod_q;
  assign mix_d = sum[2*SampleW-1:SampleW];

  always_ff @(posedge clk_i) begin
    if (adv_i.sum_en) begin
      mix_q <= mix_d;
    end
  end

  assign mix_o = mix_q;

endmodule

/* src/palette_alpha_blend_yuv_core.sv */
// top level of the palette alpha blend block: ram, three mix lanes, pipeline control
// depends on pab_pkg, pab_pal_ram and pab_mix_lane
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one word per item. A word
//   with action_i = write stores entry_* at pixel_index_i and gives no result.
//   A word with action_i = blend looks up pixel_index_i and gives one result
//   word on the output channel (out_valid_o / out_stall_i).
//   cfg_we_i / cfg_data_i set the palette entry count; indices at or above it
//   pass the destination samples through with both changed flags low.
//   Pipeline: a blend word has its ram read made at the accepting edge, then
//   moves through the product stage into the sum stage, whose register is the
//   output register from which it is offered on the output channel.
//   Throughput: one word per cycle while in_stall_o is low, set by the single
//   ram port that serves either one write or one read each cycle.
//   Stalls: each stage moves only when the next one is empty or moving, so
//   bubbles are filled; with all three stages full and the output stalled,
//   in_stall_o is raised. The output word holds steady while stalled.
//   Reset clears the pipeline valids and the entry count (all transparent);
//   palette contents are undefined until written, no clearing pass is made.
module palette_alpha_blend_yuv_core
  import pab_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [CountW-1:0]   cfg_data_i,
  // input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                action_i,
  input  logic [PalAw-1:0]    pixel_index_i,
  input  logic [SampleW-1:0]  entry_luma_i,
  input  logic [SampleW-1:0]  entry_cb_i,
  input  logic [SampleW-1:0]  entry_cr_i,
  input  logic [SampleW-1:0]  entry_alpha_i,
  input  logic [SampleW-1:0]  dest_luma_i,
  input  logic [SampleW-1:0]  dest_cb_i,
  input  logic [SampleW-1:0]  dest_cr_i,
  input  logic                chroma_site_i,
  // output channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [SampleW-1:0]  out_luma_o,
  output logic [SampleW-1:0]  out_cb_o,
  output logic [SampleW-1:0]  out_cr_o,
  output logic                luma_changed_o,
  output logic                chroma_changed_o
);

  logic [CountW-1:0]  entries_q;
  logic               accept;
  logic               is_write;
  logic               hit;
  logic               out_ready, s2_ready, s1_ready;
  pab_entry_t         wentry;
  pab_entry_t         rentry;
  pab_adv_t           adv;

  // read stage
  logic               s1_valid_q;
  logic               s1_hit_q, s1_site_q;
  logic [SampleW-1:0] s1_dl_q, s1_dcb_q, s1_dcr_q;
  // product stage
  logic               s2_valid_q;
  logic               s2_hit_q, s2_site_q;
  // output stage
  logic               out_valid_q;
  logic               out_hit_q, out_site_q;

  // gated palette values: a pass-through uses alpha 0 and pal 0, giving dest
  logic [SampleW-1:0] pal_y, pal_u, pal_v, pal_a;
  logic [SampleW-1:0] mix_y, mix_u, mix_v;

  // entry count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= '0;
    end else if (cfg_we_i) begin
      entries_q <= cfg_data_i;
    end
  end

  // pipeline flow control
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s2_ready   = !s2_valid_q || out_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_stall_o = !s1_ready;
  assign accept     = in_valid_i && s1_ready;
  assign is_write   = (pab_action_e'(action_i) == ACT_WRITE);
  assign hit        = ({1'b0, pixel_index_i} < entries_q);

  assign adv.prod_en = s2_ready;
  assign adv.sum_en  = out_ready;

  // palette store
  assign wentry = '{alpha: entry_alpha_i, cr: entry_cr_i, cb: entry_cb_i, luma: entry_luma_i};

  pab_pal_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (accept && is_write),
    .re_i    (accept && !is_write),
    .addr_i  (pixel_index_i),
    .wdata_i (wentry),
    .rdata_o (rentry)
  );

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= accept && !is_write;
      if (s2_ready) s2_valid_q <= s1_valid_q;
      if (out_ready) out_valid_q <= s2_valid_q;
    end
  end

  // side fields along the pipe
  always_ff @(posedge clk_i) begin
    if (accept && !is_write) begin
      s1_hit_q  <= hit;
      s1_site_q <= chroma_site_i;
      s1_dl_q   <= dest_luma_i;
      s1_dcb_q  <= dest_cb_i;
      s1_dcr_q  <= dest_cr_i;
    end
    if (s2_ready) begin
      s2_hit_q  <= s1_hit_q;
      s2_site_q <= s1_site_q;
    end
    if (out_ready) begin
      out_hit_q  <= s2_hit_q;
      out_site_q <= s2_site_q;
    end
  end

  assign pal_y = s1_hit_q ? rentry.luma  : '0;
  assign pal_u = s1_hit_q ? rentry.cb    : '0;
  assign pal_v = s1_hit_q ? rentry.cr    : '0;
  assign pal_a = s1_hit_q ? rentry.alpha : '0;

  // one lane per channel
  pab_mix_lane u_lane_y (
    .clk_i (clk_i), .adv_i (adv), .dest_i (s1_dl_q),
    .pal_i (pal_y), .alpha_i (pal_a), .mix_o (mix_y)
  );

  pab_mix_lane u_lane_u (
    .clk_i (clk_i), .adv_i (adv), .dest_i (s1_dcb_q),
    .pal_i (pal_u), .alpha_i (pal_a), .mix_o (mix_u)
  );

  pab_mix_lane u_lane_v (
    .clk_i (clk_i), .adv_i (adv), .dest_i (s1_dcr_q),
    .pal_i (pal_v), .alpha_i (pal_a), .mix_o (mix_v)
  );

  // output word
  assign out_valid_o      = out_valid_q;
  assign out_luma_o       = mix_y;
  assign out_cb_o         = out_site_q ? mix_u : '0;
  assign out_cr_o         = out_site_q ? mix_v : '0;
  assign luma_changed_o   = out_hit_q;
  assign chroma_changed_o = out_hit_q && out_site_q;

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// self-checking testbench for palette_alpha_blend_yuv_core: directed table, then random words
// depends on pab_pkg and the rtl of the block; checks against a behavioral mirror of the palette
module tb
  import pab_pkg::*;
;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 40;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned PhaseWords = 150;

  typedef enum logic [0:0] {
    RK_CFG  = 1'b0,
    RK_WORD = 1'b1
  } row_kind_e;

  typedef struct packed {
    pab_action_e        act;
    logic [PalAw-1:0]   idx;
    pab_entry_t         ent;
    logic [SampleW-1:0] dl;
    logic [SampleW-1:0] dcb;
    logic [SampleW-1:0] dcr;
    logic               site;
  } pixel_word_t;

  typedef struct packed {
    logic [SampleW-1:0] luma;
    logic [SampleW-1:0] cb;
    logic [SampleW-1:0] cr;
    logic               lc;
    logic               cc;
  } pixel_out_t;

  typedef struct packed {
    row_kind_e          kind;
    logic [CountW-1:0]  cnt;
    pixel_word_t        w;
    logic               typed;
    pixel_out_t         x;
  } dir_row_t;

  // directed words: entry packs as alpha, cr, cb, luma from msb down
  localparam int NumRows = 24;
  localparam dir_row_t DirTable [NumRows] = '{
    // entry count is zero after reset, so everything passes through
    '{RK_WORD, 9'd0, '{ACT_BLEND, 8'h00, 32'h0, 8'hFF, 8'h00, 8'hFF, 1'b1},
      1'b1, '{8'hFF, 8'h00, 8'hFF, 1'b0, 1'b0}},
    '{RK_WORD, 9'd0, '{ACT_BLEND, 8'hFF, 32'h0, 8'h80, 8'h12, 8'h34, 1'b0},
      1'b1, '{8'h80, 8'h00, 8'h00, 1'b0, 1'b0}},
    '{RK_WORD, 9'd0, '{ACT_WRITE, 8'h00, 32'hFFFF00FF, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, '0},
    '{RK_WORD, 9'd0, '{ACT_WRITE, 8'h01, 32'h0000FF00, 8'hFF, 8'hFF, 8'hFF, 1'b1}, 1'b0, '0},
    '{RK_WORD, 9'd0, '{ACT_WRITE, 8'hFF, 32'h800F55AA, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, '0},
    '{RK_WORD, 9'd0, '{ACT_WRITE, 8'h02, 32'hC33CA55A, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, '0},
    '{RK_CFG, 9'd256, '0, 1'b0, '0},
    // opaque entry gives the palette color, fully clear entry keeps the destination
    '{RK_WORD, 9'd0, '{ACT_BLEND, 8'h00, 32'h0, 8'h00, 8'hFF, 8'h00, 1'b1},
      1'b1, '{8'hFF, 8'h00, 8'hFF, 1'b1, 1'b1}},
    '{RK_WORD, 9'd0, '{ACT_BLEND, 8'h00, 32'h0, 8'h00, 8'h5A, 8'hA5, 1'b0},
      1'b1, '{8'hFF, 8'h00, 8'h00, 1'b1, 1'b0}},
    '{RK_WORD, 9'd0, '{ACT_BLEND, 8'h01, 32'h0, 8'hFF, 8'h00, 8'hFF, 1'b1},
      1'b1, '{8'hFF, 8'h00, 8'hFF, 1'b1, 1'b1}},
    '{RK_WORD, 9'd0, '{ACT_BLEND, 8'hFF, 32'h0, 8'h00, 8'hFF, 8'h81, 1'b1}, 1'b0, '0},
    '{RK_WORD, 9'd0, '{ACT_BLEND, 8'h02, 32'h0, 8'h7E, 8'h01, 8'hFE, 1'b0}, 1'b0, '0},
    '{RK_CFG, 9'd2, '0, 1'b0, '0},
    // index at the count and far above it are transparent
    '{RK_WORD, 9'd0, '{ACT_BLEND, 8'h02, 32'h0, 8'h33, 8'h44, 8'h55, 1'b1},
      1'b1, '{8'h33, 8'h44, 8'h55, 1'b0, 1'b0}},
    '{RK_WORD, 9'd0, '{ACT_BLEND, 8'h01, 32'h0, 8'h10, 8'h20, 8'h30, 1'b1},
      1'b1, '{8'h10, 8'h20, 8'h30, 1'b1, 1'b1}},
    '{RK_WORD, 9'd0, '{ACT_BLEND, 8'hFF, 32'h0, 8'hC0, 8'h0C, 8'hCC, 1'b0},
      1'b1, '{8'hC0, 8'h00, 8'h00, 1'b0, 1'b0}},
    // count above the palette depth acts as the full depth
    '{RK_CFG, 9'd511, '0, 1'b0, '0},
    '{RK_WORD, 9'd0, '{ACT_BLEND, 8'hFF, 32'h0, 8'h12, 8'h34, 8'h56, 1'b1}, 1'b0, '0},
    // flags stay set even when the blend leaves the samples as they were
    '{RK_WORD, 9'd0, '{ACT_WRITE, 8'h00, 32'h00000000, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, '0},
    '{RK_WORD, 9'd0, '{ACT_BLEND, 8'h00, 32'h0, 8'hFF, 8'h80, 8'h01, 1'b1},
      1'b1, '{8'hFF, 8'h80, 8'h01, 1'b1, 1'b1}},
    // write followed by a read of the same entry
    '{RK_WORD, 9'd0, '{ACT_WRITE, 8'h03, 32'h7F01FE80, 8'h00, 8'h00, 8'h00, 1'b1}, 1'b0, '0},
    '{RK_WORD, 9'd0, '{ACT_BLEND, 8'h03, 32'h0, 8'h01, 8'hFE, 8'h7F, 1'b1}, 1'b0, '0},
    '{RK_CFG, 9'd0, '0, 1'b0, '0},
    '{RK_WORD, 9'd0, '{ACT_BLEND, 8'h00, 32'h0, 8'h00, 8'h00, 8'h00, 1'b1},
      1'b1, '{8'h00, 8'h00, 8'h00, 1'b0, 1'b0}}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CountW-1:0]  cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               action_i;
  logic [PalAw-1:0]   pixel_index_i;
  logic [SampleW-1:0] entry_luma_i;
  logic [SampleW-1:0] entry_cb_i;
  logic [SampleW-1:0] entry_cr_i;
  logic [SampleW-1:0] entry_alpha_i;
  logic [SampleW-1:0] dest_luma_i;
  logic [SampleW-1:0] dest_cb_i;
  logic [SampleW-1:0] dest_cr_i;
  logic               chroma_site_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [SampleW-1:0] out_luma_o;
  logic [SampleW-1:0] out_cb_o;
  logic [SampleW-1:0] out_cr_o;
  logic               luma_changed_o;
  logic               chroma_changed_o;

  // mirror of the palette and the entry count
  pab_entry_t         palette_mirror [PalDepth];
  bit [PalDepth-1:0]  entry_loaded;
  logic [CountW-1:0]  entry_count;
  pixel_out_t         pixels_due [$];
  int unsigned        mismatches;
  int unsigned        cycles;
  bit                 steady;
  bit                 hold_out_req;

  palette_alpha_blend_yuv_core i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .pixel_index_i    (pixel_index_i),
    .entry_luma_i     (entry_luma_i),
    .entry_cb_i       (entry_cb_i),
    .entry_cr_i       (entry_cr_i),
    .entry_alpha_i    (entry_alpha_i),
    .dest_luma_i      (dest_luma_i),
    .dest_cb_i        (dest_cb_i),
    .dest_cr_i        (dest_cr_i),
    .chroma_site_i    (chroma_site_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_luma_o       (out_luma_o),
    .out_cb_o         (out_cb_o),
    .out_cr_o         (out_cr_o),
    .luma_changed_o   (luma_changed_o),
    .chroma_changed_o (chroma_changed_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("[palette_alpha_blend_yuv_core] ERROR");
    $finish;
  end

  // entries that blend, with counts above the depth clipped
  function automatic int live_entries();
    return (int'(entry_count) > int'(PalDepth)) ? int'(PalDepth) : int'(entry_count);
  endfunction

  // one channel: (dest*(256-a) + pal*(1+a)) >> 8
  function automatic logic [SampleW-1:0] mix_sample(logic [SampleW-1:0] d,
                                                   logic [SampleW-1:0] p,
                                                   logic [SampleW-1:0] a);
    logic [17:0] acc;
    acc = 18'(d) * (18'd256 - 18'(a)) + 18'(p) * (18'd1 + 18'(a));
    return acc[15:8];
  endfunction

  // expected output word for one blend word
  function automatic pixel_out_t blend_pixel(pixel_word_t w);
    pixel_out_t r;
    pab_entry_t e;
    r.luma = w.dl;
    r.cb   = w.site ? w.dcb : '0;
    r.cr   = w.site ? w.dcr : '0;
    r.lc   = 1'b0;
    r.cc   = 1'b0;
    if (int'(w.idx) < live_entries()) begin
      e      = palette_mirror[w.idx];
      r.luma = mix_sample(w.dl, e.luma, e.alpha);
      if (w.site) begin
        r.cb = mix_sample(w.dcb, e.cb, e.alpha);
        r.cr = mix_sample(w.dcr, e.cr, e.alpha);
      end
      r.lc = 1'b1;
      r.cc = w.site;
    end
    return r;
  endfunction

  // random word; a blend that would hit an unloaded live entry loads it instead
  function automatic pixel_word_t random_pixel_word();
    pixel_word_t w;
    int lim;
    lim   = live_entries();
    w.act = ($urandom_range(0, 3) == 0) ? ACT_WRITE : ACT_BLEND;
    if (lim > 0 && $urandom_range(0, 4) != 0) w.idx = PalAw'($urandom_range(0, lim - 1));
    else w.idx = PalAw'($urandom);
    w.ent = pab_entry_t'($urandom);
    if ($urandom_range(0, 3) == 0) w.ent.alpha = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    w.dl   = SampleW'($urandom);
    w.dcb  = SampleW'($urandom);
    w.dcr  = SampleW'($urandom);
    w.site = 1'($urandom);
    if (w.act == ACT_BLEND && int'(w.idx) < lim && !entry_loaded[w.idx]) w.act = ACT_WRITE;
    return w;
  endfunction

  // offer one word, wait for it to be taken, then update the mirror
  task automatic send_word(input pixel_word_t w, input bit typed, input pixel_out_t typed_res);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    action_i      <= w.act;
    pixel_index_i <= w.idx;
    entry_luma_i  <= w.ent.luma;
    entry_cb_i    <= w.ent.cb;
    entry_cr_i    <= w.ent.cr;
    entry_alpha_i <= w.ent.alpha;
    dest_luma_i   <= w.dl;
    dest_cb_i     <= w.dcb;
    dest_cr_i     <= w.dcr;
    chroma_site_i <= w.site;
    in_valid_i    <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    if (w.act == ACT_WRITE) begin
      palette_mirror[w.idx] = w.ent;
      entry_loaded[w.idx]   = 1'b1;
    end else begin
      pixels_due.push_back(typed ? typed_res : blend_pixel(w));
    end
    @(negedge clk_i);
  endtask

  // stop sending until every result is back and trailing writes have settled
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pixels_due.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic set_entry_count(input logic [CountW-1:0] cnt);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= cnt;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    entry_count = cnt;
  endtask

  task automatic check_field(input string fname, input logic [SampleW-1:0] want,
                             input logic [SampleW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, fname, want, got);
      mismatches++;
    end
  endtask

  // result side: random stalls, one long hold on request
  initial begin : result_sink
    int n;
    pixel_out_t want;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_out_req) begin
        n = HoldCycles;
        hold_out_req = 1'b0;
      end else begin
        n = steady ? 0 : $urandom_range(0, 11);
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      if (pixels_due.size() == 0) begin
        $display("%0t: result word with nothing expected, expected none actual %h %h %h %b %b",
                 $time, out_luma_o, out_cb_o, out_cr_o, luma_changed_o, chroma_changed_o);
        mismatches++;
      end else begin
        want = pixels_due.pop_front();
        check_field("out_luma", want.luma, out_luma_o);
        check_field("out_cb", want.cb, out_cb_o);
        check_field("out_cr", want.cr, out_cr_o);
        check_field("luma_changed", SampleW'(want.lc), SampleW'(luma_changed_o));
        check_field("chroma_changed", SampleW'(want.cc), SampleW'(chroma_changed_o));
      end
    end
  end

  // stimulus
  initial begin : stimulus
    logic [CountW-1:0] cnt;
    mismatches    = 0;
    steady        = 1'b0;
    hold_out_req  = 1'b0;
    entry_count   = '0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    action_i      = ACT_BLEND;
    pixel_index_i = '0;
    entry_luma_i  = '0;
    entry_cb_i    = '0;
    entry_cr_i    = '0;
    entry_alpha_i = '0;
    dest_luma_i   = '0;
    dest_cb_i     = '0;
    dest_cr_i     = '0;
    chroma_site_i = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table
    for (int i = 0; i < NumRows; i++) begin
      if (DirTable[i].kind == RK_CFG) set_entry_count(DirTable[i].cnt);
      else send_word(DirTable[i].w, DirTable[i].typed, DirTable[i].x);
    end

    // random phases, each under its own entry count
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: cnt = 9'd256;
        1: cnt = 9'd511;
        2: cnt = 9'd0;
        3: cnt = 9'd1;
        4: cnt = 9'd255;
        default: cnt = CountW'($urandom_range(0, 256));
      endcase
      set_entry_count(cnt);
      steady = (ph % 4 == 1);
      for (int k = 0; k < PhaseWords; k++) begin
        // back up the whole pipe behind a long output hold
        if (ph == 3 && k == 50) begin
          steady       = 1'b1;
          hold_out_req = 1'b1;
        end
        if (ph == 3 && k == 100) steady = 1'b0;
        if (ph == 6 && k == 75) drain();
        send_word(random_pixel_word(), 1'b0, '0);
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("[palette_alpha_blend_yuv_core] OK");
    end else begin
      $display("[palette_alpha_blend_yuv_core] ERROR");
    end
    $finish;
  end

endmodule

/* palette_alpha_blend_yuv_core.f */
src/pab_pkg.sv
src/pab_pal_ram.sv
src/pab_mix_lane.sv
src/palette_alpha_blend_yuv_core.sv
verif/tb.sv
